/* rtl/core/kpvt_pkg.sv */
package kpvt_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DIV_STEPS = 88;   // 64 numerator bits plus the fraction bits
  localparam int UC_LAST   = 32;

  localparam logic [2:0] CFG_Q_POS     = 3'd0;
  localparam logic [2:0] CFG_Q_POS_VEL = 3'd1;
  localparam logic [2:0] CFG_Q_VEL_POS = 3'd2;
  localparam logic [2:0] CFG_Q_VEL     = 3'd3;
  localparam logic [2:0] CFG_R_MEAS    = 3'd4;
  localparam logic [2:0] CFG_INIT_P    = 3'd5;
  localparam logic [2:0] CFG_INIT_X    = 3'd6;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [1:0] {
    U_ADD = 2'd0,
    U_SUB = 2'd1,
    U_MUL = 2'd2,
    U_DIV = 2'd3
  } uop_t;

  typedef enum logic [4:0] {
    R_X, R_V, R_P0, R_P1, R_P2, R_P3, R_T, R_A, R_Y0, R_Y1, R_K,
    R_DT, R_M, R_OLDX, R_Q0, R_Q1, R_Q2, R_Q3, R_R, R_ZERO
  } rsel_t;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_t;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_ISSUE = 4'b0010,
    T_WAIT  = 4'b0100,
    T_DONE  = 4'b1000
  } top_state_t;

endpackage

/* rtl/core/kpvt_alu.sv */
module kpvt_alu
  import kpvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  alu_req_t           req,
  input  logic signed [63:0] opa,
  input  logic signed [63:0] opb,
  output logic               done,
  output logic signed [63:0] result
);

  alu_state_t   st_r;
  logic [6:0]   cnt_r;
  logic         neg_r, is_mul_r, dzero_r;
  logic [63:0]  ua_r, ub_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [87:0]  num_r;
  logic [63:0]  rem_r;

  logic [31:0]  pa, pb;
  logic [127:0] pp_sh;
  logic [64:0]  rem_sh, rem_dif;
  logic [63:0]  mag, ua_in, ub_in;
  logic         ovf;

  assign ua_in = opa[63] ? 64'(-opa) : 64'(opa);
  assign ub_in = opb[63] ? 64'(-opb) : 64'(opb);

  // partial product schedule: a0b0, a0b1, a1b0, a1b1; each product is registered and accumulated in the next cycle
  always_comb begin
    pa    = ua_r[31:0];
    pb    = ub_r[31:0];
    pp_sh = {64'b0, pp_r};
    case (cnt_r[2:0])
      3'd0: begin pa = ua_r[31:0];  pb = ub_r[31:0];  end
      3'd1: begin pa = ua_r[31:0];  pb = ub_r[63:32]; end
      3'd2: begin pa = ua_r[63:32]; pb = ub_r[31:0];  pp_sh = {32'b0, pp_r, 32'b0}; end
      3'd3: begin pa = ua_r[63:32]; pb = ub_r[63:32]; pp_sh = {32'b0, pp_r, 32'b0}; end
      3'd4: pp_sh = {pp_r, 64'b0};
      default: pp_sh = {64'b0, pp_r};
    endcase
  end

  assign rem_sh  = {rem_r, num_r[87]};
  assign rem_dif = rem_sh - {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      case (st_r)
        A_IDLE: begin
          if (req.start) begin
            st_r     <= (req.op == OP_MUL) ? A_MUL : A_DIV;
            neg_r    <= opa[63] ^ opb[63];
            is_mul_r <= (req.op == OP_MUL);
            dzero_r  <= (opb == 64'sd0);
            ua_r     <= ua_in;
            ub_r     <= ub_in;
            cnt_r    <= '0;
            acc_r    <= '0;
            num_r    <= {ua_in, 24'b0};
            rem_r    <= '0;
          end
        end
        A_MUL: begin
          pp_r <= {32'b0, pa} * {32'b0, pb};
          if (cnt_r != 7'd0) acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd4) st_r <= A_FIN;
        end
        A_DIV: begin
          if (!rem_dif[64]) begin
            rem_r <= rem_dif[63:0];
            num_r <= {num_r[86:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            num_r <= {num_r[86:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) st_r <= A_FIN;
        end
        A_FIN: st_r <= A_IDLE;
        default: st_r <= A_IDLE;
      endcase
    end
  end

  always_comb begin
    if (is_mul_r) begin
      ovf = |acc_r[127:88];
      mag = acc_r[87:24];
    end else begin
      ovf = |num_r[87:63];
      mag = num_r[63:0];
    end
    if (ovf) mag = '1;
    if (!is_mul_r && dzero_r) begin
      result = 64'sd0;
    end else if (neg_r) begin
      result = mag[63] ? {1'b1, 63'b0} : 64'(-mag);
    end else begin
      result = mag[63] ? {1'b0, {63{1'b1}}} : 64'(mag);
    end
  end

  assign done = (st_r == A_FIN);

endmodule

/* rtl/core/kalman_pos_vel_tracker.sv */
// Init item: the state is loaded on acceptance and the result is registered from T_DONE.
// Update item: a microcoded sequence over one shared multiply/divide unit;
// a multiply or divide holds the sequence until the unit finishes, and an update
// takes less time on a zero time step or zero gain, where unit operations are skipped.
// One item in flight; a new one is taken while a result waits.
// Reset (synchronous, rst_n low): state to p00 = p11 = 1.0, registers to defaults.
module kalman_pos_vel_tracker
  import kpvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_measurement,
  input  logic [23:0]        in_dt_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_estimate,
  output logic               out_dt_fault,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  top_state_t st_r;
  logic [5:0] uc_r;
  logic [31:0] q0_r, q1_r, q2_r, q3_r, rm_r, ip_r, ix_r;
  logic signed [63:0] x_r, v_r, p0_r, p1_r, p2_r, p3_r, t_r, a_r, y0_r, y1_r, k_r;
  logic signed [63:0] m_r, oldx_r;
  logic [23:0] dt_r;
  logic fault_r;
  logic out_valid_r, out_fault_r;
  logic signed [31:0] out_est_r;

  uop_t  uop;
  rsel_t sa, sb, sd;
  logic  skip, kzero;
  logic signed [63:0] va, vb, alu_res, wr_data;
  logic [64:0] sum;
  logic wr_en;
  alu_req_t req;
  logic alu_done;
  logic accept, fin;
  logic [63:0] xmag;
  logic [39:0] xint;
  logic signed [31:0] est;

  function automatic logic signed [63:0] rd(input rsel_t s,
      input logic signed [63:0] x, v, p0, p1, p2, p3, t, a, y0, y1, k, m, ox,
      input logic [23:0] dt, input logic [31:0] q0, q1, q2, q3, r);
    logic signed [63:0] o;
    case (s)
      R_X:    o = x;
      R_V:    o = v;
      R_P0:   o = p0;
      R_P1:   o = p1;
      R_P2:   o = p2;
      R_P3:   o = p3;
      R_T:    o = t;
      R_A:    o = a;
      R_Y0:   o = y0;
      R_Y1:   o = y1;
      R_K:    o = k;
      R_DT:   o = {36'b0, dt, 4'b0};
      R_M:    o = m;
      R_OLDX: o = ox;
      R_Q0:   o = {24'b0, q0, 8'b0};
      R_Q1:   o = {24'b0, q1, 8'b0};
      R_Q2:   o = {24'b0, q2, 8'b0};
      R_Q3:   o = {24'b0, q3, 8'b0};
      R_R:    o = {24'b0, r, 8'b0};
      default: o = 64'sd0;
    endcase
    return o;
  endfunction

  // microprogram
  always_comb begin
    uop = U_ADD; sa = R_ZERO; sb = R_ZERO; sd = R_T;
    case (uc_r)
      6'd0:  begin uop = U_MUL; sa = R_DT; sb = R_V;  sd = R_T;  end
      6'd1:  begin uop = U_ADD; sa = R_X;  sb = R_T;  sd = R_X;  end
      6'd2:  begin uop = U_ADD; sa = R_P2; sb = R_P1; sd = R_T;  end
      6'd3:  begin uop = U_MUL; sa = R_DT; sb = R_T;  sd = R_T;  end
      6'd4:  begin uop = U_ADD; sa = R_P0; sb = R_T;  sd = R_A;  end
      6'd5:  begin uop = U_MUL; sa = R_DT; sb = R_DT; sd = R_T;  end
      6'd6:  begin uop = U_MUL; sa = R_T;  sb = R_P3; sd = R_T;  end
      6'd7:  begin uop = U_ADD; sa = R_A;  sb = R_T;  sd = R_A;  end
      6'd8:  begin uop = U_ADD; sa = R_A;  sb = R_Q0; sd = R_P0; end
      6'd9:  begin uop = U_MUL; sa = R_DT; sb = R_P3; sd = R_T;  end
      6'd10: begin uop = U_ADD; sa = R_P1; sb = R_T;  sd = R_P1; end
      6'd11: begin uop = U_ADD; sa = R_P1; sb = R_Q1; sd = R_P1; end
      6'd12: begin uop = U_ADD; sa = R_P2; sb = R_T;  sd = R_P2; end
      6'd13: begin uop = U_ADD; sa = R_P2; sb = R_Q2; sd = R_P2; end
      6'd14: begin uop = U_ADD; sa = R_P3; sb = R_Q3; sd = R_P3; end
      6'd15: begin uop = U_SUB; sa = R_M;  sb = R_X;  sd = R_Y0; end
      6'd16: begin uop = U_SUB; sa = R_M;  sb = R_OLDX; sd = R_T; end
      6'd17: begin uop = U_DIV; sa = R_T;  sb = R_DT; sd = R_T;  end
      6'd18: begin uop = U_SUB; sa = R_T;  sb = R_V;  sd = R_Y1; end
      6'd19: begin uop = U_ADD; sa = R_P0; sb = R_R;  sd = R_A;  end
      6'd20: begin uop = U_DIV; sa = R_P0; sb = R_A;  sd = R_K;  end
      6'd21: begin uop = U_MUL; sa = R_Y0; sb = R_K;  sd = R_T;  end
      6'd22: begin uop = U_ADD; sa = R_X;  sb = R_T;  sd = R_X;  end
      6'd23: begin uop = U_MUL; sa = R_Y1; sb = R_K;  sd = R_T;  end
      6'd24: begin uop = U_ADD; sa = R_V;  sb = R_T;  sd = R_V;  end
      6'd25: begin uop = U_MUL; sa = R_K;  sb = R_P0; sd = R_T;  end
      6'd26: begin uop = U_SUB; sa = R_P0; sb = R_T;  sd = R_P0; end
      6'd27: begin uop = U_MUL; sa = R_K;  sb = R_P1; sd = R_T;  end
      6'd28: begin uop = U_SUB; sa = R_P1; sb = R_T;  sd = R_P1; end
      6'd29: begin uop = U_MUL; sa = R_K;  sb = R_P2; sd = R_T;  end
      6'd30: begin uop = U_SUB; sa = R_P2; sb = R_T;  sd = R_P2; end
      6'd31: begin uop = U_MUL; sa = R_K;  sb = R_P3; sd = R_T;  end
      6'd32: begin uop = U_SUB; sa = R_P3; sb = R_T;  sd = R_P3; end
      default: begin uop = U_ADD; sa = R_ZERO; sb = R_ZERO; sd = R_T; end
    endcase
  end

  // velocity path is dropped on a zero time step
  assign skip  = fault_r && (uc_r == 6'd16 || uc_r == 6'd17 || uc_r == 6'd18 ||
                             uc_r == 6'd23 || uc_r == 6'd24);
  // non-positive innovation variance gives zero gain
  assign kzero = (uc_r == 6'd20) && (a_r[63] || a_r == 64'sd0);

  assign va = rd(sa, x_r, v_r, p0_r, p1_r, p2_r, p3_r, t_r, a_r, y0_r, y1_r, k_r,
                 m_r, oldx_r, dt_r, q0_r, q1_r, q2_r, q3_r, rm_r);
  assign vb = rd(sb, x_r, v_r, p0_r, p1_r, p2_r, p3_r, t_r, a_r, y0_r, y1_r, k_r,
                 m_r, oldx_r, dt_r, q0_r, q1_r, q2_r, q3_r, rm_r);

  assign sum = (uop == U_SUB) ? ({va[63], va} - {vb[63], vb}) : ({va[63], va} + {vb[63], vb});

  assign req.start = (st_r == T_ISSUE) && !skip && !kzero && (uop == U_MUL || uop == U_DIV);
  assign req.op    = (uop == U_MUL) ? OP_MUL : OP_DIV;

  kpvt_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (va),
    .opb    (vb),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_data = alu_res;
    if (st_r == T_WAIT) begin
      wr_en = alu_done;
    end else if (st_r == T_ISSUE && !skip) begin
      if (kzero) begin
        wr_en   = 1'b1;
        wr_data = 64'sd0;
      end else if (uop == U_ADD || uop == U_SUB) begin
        wr_en = 1'b1;
        if (sum[64] != sum[63]) wr_data = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else wr_data = sum[63:0];
      end
    end
  end

  // a step completes on an inline op, a skip, a forced zero gain, or the unit finishing
  assign fin = (st_r == T_ISSUE && !req.start) || (st_r == T_WAIT && alu_done);

  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != T_IDLE);

  assign xmag = x_r[63] ? 64'(-x_r) : 64'(x_r);
  assign xint = xmag[63:24];
  always_comb begin
    if (x_r[63]) est = (xint > 40'h0080000000) ? 32'sh80000000 : 32'(-xint);
    else         est = (xint > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : 32'(xint);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      uc_r        <= '0;
      out_valid_r <= 1'b0;
      q0_r <= 32'd65536; q1_r <= 32'd66; q2_r <= '0; q3_r <= '0;
      rm_r <= 32'd65536; ip_r <= 32'd65536; ix_r <= '0;
      x_r  <= '0; v_r <= '0;
      p0_r <= 64'sd1 <<< FRAC_BITS; p1_r <= '0; p2_r <= '0; p3_r <= 64'sd1 <<< FRAC_BITS;
    end else begin
      // T_DONE reloads the output register itself
      if (out_valid_r && !out_stall && st_r != T_DONE) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_Q_POS:     q0_r <= cfg_wdata;
          CFG_Q_POS_VEL: q1_r <= cfg_wdata;
          CFG_Q_VEL_POS: q2_r <= cfg_wdata;
          CFG_Q_VEL:     q3_r <= cfg_wdata;
          CFG_R_MEAS:    rm_r <= cfg_wdata;
          CFG_INIT_P:    ip_r <= cfg_wdata;
          CFG_INIT_X:    ix_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (wr_en) begin
        case (sd)
          R_X:  x_r  <= wr_data;
          R_V:  v_r  <= wr_data;
          R_P0: p0_r <= wr_data;
          R_P1: p1_r <= wr_data;
          R_P2: p2_r <= wr_data;
          R_P3: p3_r <= wr_data;
          R_T:  t_r  <= wr_data;
          R_A:  a_r  <= wr_data;
          R_Y0: y0_r <= wr_data;
          R_Y1: y1_r <= wr_data;
          R_K:  k_r  <= wr_data;
          default: ;
        endcase
      end

      case (st_r)
        T_IDLE: begin
          if (accept) begin
            if (in_func) begin
              x_r     <= {{8{ix_r[31]}}, ix_r, 24'b0};
              v_r     <= '0;
              p0_r    <= {24'b0, ip_r, 8'b0};
              p3_r    <= {24'b0, ip_r, 8'b0};
              p1_r    <= '0;
              p2_r    <= '0;
              fault_r <= 1'b0;
              st_r    <= T_DONE;
            end else begin
              m_r     <= {{8{in_measurement[31]}}, in_measurement, 24'b0};
              dt_r    <= in_dt_step;
              oldx_r  <= x_r;
              fault_r <= (in_dt_step == 24'd0);
              uc_r    <= '0;
              st_r    <= T_ISSUE;
            end
          end
        end
        T_ISSUE, T_WAIT: begin
          if (req.start) begin
            st_r <= T_WAIT;
          end else if (fin) begin
            if (uc_r == 6'(UC_LAST)) st_r <= T_DONE;
            else begin
              uc_r <= uc_r + 6'd1;
              st_r <= T_ISSUE;
            end
          end
        end
        T_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_est_r   <= est;
            out_fault_r <= fault_r;
            st_r        <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_dt_fault = out_fault_r;

endmodule

/* test/kpvt_checker.sv */
module kpvt_checker
  import kpvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic signed [31:0] in_measurement,
  input  logic [23:0]        in_dt_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_estimate,
  input  logic               out_dt_fault,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 mismatches,
  output int                 pending
);

  localparam logic FUNC_INIT = 1'b1;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef logic signed [63:0] q24_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic               dt_fault;
  } track_result_t;

  track_result_t expected_q[$];

  logic [31:0] q_noise [4];
  logic [31:0] r_noise;
  logic [31:0] p_start;
  logic [31:0] x_start;
  q24_t        pos_q, vel_q;
  q24_t        cov_q [4];

  function automatic logic [63:0] mag64(q24_t a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic q24_t from_mag(logic neg, logic [127:0] m);
    if (neg) begin
      if (m >= 128'h8000_0000_0000_0000) return S64_MIN;
      return -$signed(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return S64_MAX;
    return $signed(m[63:0]);
  endfunction

  // overflow shows as the two top bits of the 65-bit sum differing
  function automatic q24_t sat_sum(q24_t a, q24_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic q24_t sat_diff(q24_t a, q24_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic q24_t q_mul(q24_t a, q24_t b);
    logic [127:0] prod;
    logic         neg;
    neg  = a[63] ^ b[63];
    prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    if ((prod >> 88) != 0) return from_mag(neg, {128{1'b1}});
    return from_mag(neg, prod >> 24);
  endfunction

  function automatic q24_t q_div(q24_t n, q24_t d);
    logic [127:0] un, ud;
    logic         neg;
    neg = n[63] ^ d[63];
    un  = {64'd0, mag64(n)};
    ud  = {64'd0, mag64(d)};
    if (ud == 0) return 64'sd0;
    if (un / ud >= (128'd1 << 39)) return from_mag(neg, {128{1'b1}});
    return from_mag(neg, (un << 24) / ud);
  endfunction

  function automatic q24_t q16_to_q24(logic [31:0] v);
    return {24'd0, v, 8'd0};
  endfunction

  // advance the tracker by one transaction and return what it reports
  function automatic track_result_t track_step(logic func, logic signed [31:0] meas,
                                               logic [23:0] dts);
    track_result_t res;
    q24_t m, dt, old_x, p0, p1, p2, p3, y0, y1, s, k;
    logic [63:0] whole;
    logic fault;
    fault = 1'b0;
    if (func == FUNC_INIT) begin
      pos_q  = {{8{x_start[31]}}, x_start, 24'd0};
      vel_q  = 0;
      cov_q[0] = q16_to_q24(p_start);
      cov_q[3] = q16_to_q24(p_start);
      cov_q[1] = 0;
      cov_q[2] = 0;
    end else begin
      m     = {{8{meas[31]}}, meas, 24'd0};
      dt    = {36'd0, dts, 4'd0};
      old_x = pos_q;
      p0 = cov_q[0]; p1 = cov_q[1]; p2 = cov_q[2]; p3 = cov_q[3];
      y1 = 0;
      k  = 0;
      pos_q = sat_sum(pos_q, q_mul(dt, vel_q));
      cov_q[0] = sat_sum(sat_sum(sat_sum(p0, q_mul(dt, sat_sum(p2, p1))),
                                 q_mul(q_mul(dt, dt), p3)), q16_to_q24(q_noise[0]));
      cov_q[1] = sat_sum(sat_sum(p1, q_mul(dt, p3)), q16_to_q24(q_noise[1]));
      cov_q[2] = sat_sum(sat_sum(p2, q_mul(dt, p3)), q16_to_q24(q_noise[2]));
      cov_q[3] = sat_sum(p3, q16_to_q24(q_noise[3]));
      y0 = sat_diff(m, pos_q);
      if (dt == 0) fault = 1'b1;
      else y1 = sat_diff(q_div(sat_diff(m, old_x), dt), vel_q);
      s = sat_sum(cov_q[0], q16_to_q24(r_noise));
      if (s > 0) k = q_div(cov_q[0], s);
      pos_q = sat_sum(pos_q, q_mul(y0, k));
      if (!fault) vel_q = sat_sum(vel_q, q_mul(y1, k));
      for (int i = 0; i < 4; i++) cov_q[i] = sat_diff(cov_q[i], q_mul(k, cov_q[i]));
    end
    whole = mag64(pos_q) >> 24;
    if (pos_q[63]) res.estimate = (whole > 64'h8000_0000) ? 32'sh8000_0000 : -whole[31:0];
    else res.estimate = (whole > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : whole[31:0];
    res.dt_fault = fault;
    return res;
  endfunction

  always @(posedge clk) begin
    track_result_t want;
    if (!rst_n) begin
      q_noise[0] = 32'd65536; q_noise[1] = 32'd66; q_noise[2] = 0; q_noise[3] = 0;
      r_noise = 32'd65536;
      p_start = 32'd65536;
      x_start = 0;
      pos_q = 0;
      vel_q = 0;
      cov_q[0] = 64'sd1 <<< 24; cov_q[1] = 0; cov_q[2] = 0; cov_q[3] = 64'sd1 <<< 24;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q_POS:     q_noise[0] = cfg_wdata;
          CFG_Q_POS_VEL: q_noise[1] = cfg_wdata;
          CFG_Q_VEL_POS: q_noise[2] = cfg_wdata;
          CFG_Q_VEL:     q_noise[3] = cfg_wdata;
          CFG_R_MEAS:    r_noise    = cfg_wdata;
          CFG_INIT_P:    p_start    = cfg_wdata;
          CFG_INIT_X:    x_start    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: estimate %0d fault %0b", out_estimate, out_dt_fault);
        end else begin
          want = expected_q.pop_front();
          if (want.estimate !== out_estimate || want.dt_fault !== out_dt_fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: estimate exp %0d got %0d, fault exp %0b got %0b",
                       want.estimate, out_estimate, want.dt_fault, out_dt_fault);
          end
        end
      end
      // queue the new item after the compare, so a result seen in the same cycle matches an older item
      if (in_valid && !in_stall)
        expected_q.push_back(track_step(in_func, in_measurement, in_dt_step));
    end
    pending = expected_q.size();
  end

endmodule

/* test/testbench.sv */
module testbench;
  import kpvt_pkg::*;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_INIT   = 1'b1;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_func;
  logic signed [31:0] in_measurement;
  logic [23:0]        in_dt_step;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_estimate;
  logic               out_dt_fault;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  int                 mismatches;
  int                 pending;

  logic holdoff_req;
  logic holdoff_busy;
  int   burst_left;
  int   n_init, n_update, n_zero_dt;
  int   track_pos, track_vel;

  kalman_pos_vel_tracker DUT (.*);

  kpvt_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10 * 4_000_000);
    $display("timeout");
    $display("FAIL kalman_pos_vel_tracker");
    $finish;
  end

  // leaves cfg_we high; write_all drops it after the last register
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] qp, logic [31:0] qpv, logic [31:0] qvp,
                           logic [31:0] qv, logic [31:0] r, logic [31:0] p0,
                           logic [31:0] x0);
    write_reg(CFG_Q_POS, qp);
    write_reg(CFG_Q_POS_VEL, qpv);
    write_reg(CFG_Q_VEL_POS, qvp);
    write_reg(CFG_Q_VEL, qv);
    write_reg(CFG_R_MEAS, r);
    write_reg(CFG_INIT_P, p0);
    write_reg(CFG_INIT_X, x0);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic func, logic signed [31:0] meas, logic [23:0] dts);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 400) : $urandom_range(1, 6))
        @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_measurement <= meas;
    in_dt_step     <= dts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (func == FUNC_INIT) n_init++;
    else begin
      n_update++;
      if (dts == 0) n_zero_dt++;
    end
  endtask

  // follow a moving target with noisy samples, sometimes break the pattern
  task automatic random_item;
    int sel;
    logic [23:0] dts;
    logic signed [31:0] meas;
    sel = $urandom_range(0, 99);
    dts = 24'($urandom_range(1 << 16, 1 << 21));
    if (sel < 4) dts = 0;
    else if (sel < 6) dts = 24'hFF_FFFF;
    else if (sel < 12) dts = 24'($urandom);
    track_pos += track_vel * (dts >> 16) + $signed($urandom_range(0, 200)) - 100;
    meas = track_pos;
    if (sel >= 90) meas = $signed($urandom);
    if (sel >= 97) begin
      track_pos = $urandom_range(0, 20000) - 10000;
      track_vel = $urandom_range(0, 100) - 50;
      send_item(FUNC_INIT, $signed($urandom), 24'($urandom));
    end else begin
      send_item(FUNC_UPDATE, meas, dts);
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    out_stall    = 1'b0;
    holdoff_busy = 1'b0;
    @(posedge rst_n);
    forever begin
      if (holdoff_req) begin
        holdoff_busy = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        out_stall <= 1'b0;
        holdoff_busy = 1'b0;
        wait (!holdoff_req);
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 600)) begin
        @(negedge clk);
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 9) < 3);
        else out_stall <= ($urandom_range(0, 9) < 8);
        if (holdoff_req && !holdoff_busy) break;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_UPDATE;
    in_measurement = 0;
    in_dt_step     = 0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_Q_POS;
    cfg_wdata      = 0;
    holdoff_req    = 1'b0;
    burst_left     = 0;
    n_init = 0; n_update = 0; n_zero_dt = 0;
    track_pos = 0; track_vel = 3;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset state, extremes and special cases
    send_item(FUNC_UPDATE, 100, 24'h10_0000);
    send_item(FUNC_UPDATE, 32'sh7FFF_FFFF, 24'hFF_FFFF);
    send_item(FUNC_UPDATE, 32'sh8000_0000, 24'hFF_FFFF);
    send_item(FUNC_UPDATE, 32'sh8000_0000, 24'd1);
    send_item(FUNC_UPDATE, 0, 24'd0);
    send_item(FUNC_UPDATE, 32'sh7FFF_FFFF, 24'd0);
    send_item(FUNC_UPDATE, -5, 24'h00_0001);
    send_item(FUNC_INIT, 32'sh7FFF_FFFF, 24'hFF_FFFF);
    send_item(FUNC_UPDATE, 50, 24'h08_0000);
    drain();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(FUNC_INIT, 0, 0);
    send_item(FUNC_UPDATE, 32'sh8000_0000, 24'hFF_FFFF);
    send_item(FUNC_UPDATE, 32'sh7FFF_FFFF, 24'hFF_FFFF);
    send_item(FUNC_UPDATE, 0, 24'd0);
    drain();
    // zero measurement noise: gain forced to zero when p00 is zero too
    write_all(0, 0, 0, 0, 0, 0, 32'h8000_0000);
    send_item(FUNC_INIT, 0, 0);
    send_item(FUNC_UPDATE, 1000, 24'h10_0000);
    send_item(FUNC_UPDATE, -1000, 24'd0);
    drain();
    write_all(0, 0, 0, 0, 32'd1, 32'hFFFF_FFFF, 0);
    send_item(FUNC_INIT, 0, 0);
    send_item(FUNC_UPDATE, 12345, 24'h01_0000);
    send_item(FUNC_UPDATE, -12345, 24'hFF_FFFF);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: write_all(32'd65536, 32'd66, 0, 0, 32'd65536, 32'd65536, 0);
        1: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        2: write_all(0, 0, 0, 0, 32'd1, 0, 32'h7FFF_FFFF);
        default: write_all($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 12),
                           $urandom_range(0, 1 << 12), $urandom_range(0, 1 << 16),
                           $urandom_range(1, 1 << 22), $urandom, $urandom);
      endcase
      track_pos = 0;
      track_vel = $urandom_range(0, 40) - 20;
      send_item(FUNC_INIT, 0, 0);
      if (ph == 3) holdoff_req = 1'b1;
      for (int i = 0; i < 172; i++) begin
        random_item();
        if (holdoff_req && holdoff_busy) holdoff_req = 1'b0;
      end
      holdoff_req = 1'b0;
    end

    drain();
    repeat (400) @(posedge clk);
    $display("covered %0d updates (%0d with zero time step) and %0d inits",
             n_update, n_zero_dt, n_init);
    $display("over reset, extreme and random register settings");
    if (mismatches == 0) $display("PASS kalman_pos_vel_tracker");
    else $display("FAIL kalman_pos_vel_tracker");
    $finish;
  end

endmodule
